>>> hw/rtl/ssd_pkg.sv
// Shared types, constants and helpers for the stitch stream decoder.
// No dependencies; every other file in hw/rtl imports this package.
package ssd_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int MAX_BLOCKS  = 256;
	localparam int OUT_W       = 16;
	localparam int DELTA_W     = 12;
	localparam int BLOCK_W     = 8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DELTA_W-1:0]     delta_t;
	typedef logic signed [OUT_W-1:0]       out_coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [BLOCK_W-1:0] BLOCK_LAST = BLOCK_W'(MAX_BLOCKS - 1);

	// marker bytes
	localparam logic [7:0] BYTE_END0 = 8'hFF;
	localparam logic [7:0] BYTE_END1 = 8'h00;
	localparam logic [7:0] BYTE_COL0 = 8'hFE;
	localparam logic [7:0] BYTE_COL1 = 8'hB0;

	// event codes on the output
	localparam logic [1:0] EV_STITCH = 2'd0;
	localparam logic [1:0] EV_COLOR  = 2'd1;
	localparam logic [1:0] EV_END    = 2'd2;

	// command codes between front and back
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_STITCH = 2'd1;
	localparam logic [1:0] CMD_COLOR  = 2'd2;
	localparam logic [1:0] CMD_END    = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_file;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]         event_kind;
		out_coord_t         pos_x;
		out_coord_t         pos_y;
		logic               is_jump;
		logic [BLOCK_W-1:0] block_number;
		out_coord_t         min_x;
		out_coord_t         max_x;
		out_coord_t         min_y;
		out_coord_t         max_y;
	} evt_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       clear;  // new_file seen: wipe positions, bounds, blocks first
		delta_t     dx;
		delta_t     dy;
		logic       jump;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	function automatic delta_t sext7(input logic [7:0] b);
		logic signed [6:0] v;
		v = signed'(b[6:0]);
		return DELTA_W'(v);
	endfunction

	function automatic delta_t sext12(input logic [3:0] hi, input logic [7:0] lo);
		return signed'({hi, lo});
	endfunction

	function automatic coord_t sat_add(input coord_t a, input delta_t d);
		logic signed [COORD_WIDTH:0] s;
		s = (COORD_WIDTH+1)'(a) + (COORD_WIDTH+1)'(d);
		if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
			return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
		return s[COORD_WIDTH-1:0];
	endfunction

	function automatic out_coord_t to_out(input coord_t c);
		return OUT_W'(c);
	endfunction

endpackage

>>> hw/rtl/ssd_front.sv
// Front end: byte-level record parser, turns bytes into stitch/colour/end commands.
// Depends on ssd_pkg.
module ssd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ssd_pkg::byte_item_t item,
	output logic              push,
	output ssd_pkg::cmd_t     cmd
);
	import ssd_pkg::*;

	localparam logic [2:0] PH_FIRST  = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_YBYTE  = 3'd2;
	localparam logic [2:0] PH_YLOW   = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;
	localparam logic [2:0] PH_ENDED  = 3'd5;

	logic [2:0] phase_q, phase_d, phase_c;
	logic [7:0] first_byte_q, first_byte_d, first_byte_c;
	delta_t     delta_x_q, delta_x_d, delta_x_c;
	logic [3:0] y_high_q, y_high_d, y_high_c;
	logic       jump_q, jump_d, jump_c;
	logic [7:0] b;
	delta_t     dx_short;

	always_comb begin
		b = item.in_byte;
		// new_file restarts the parser before this byte is looked at
		if (item.new_file) begin
			phase_c      = PH_FIRST;
			first_byte_c = '0;
			delta_x_c    = '0;
			y_high_c     = '0;
			jump_c       = 1'b0;
		end else begin
			phase_c      = phase_q;
			first_byte_c = first_byte_q;
			delta_x_c    = delta_x_q;
			y_high_c     = y_high_q;
			jump_c       = jump_q;
		end

		phase_d      = phase_c;
		first_byte_d = first_byte_c;
		delta_x_d    = delta_x_c;
		y_high_d     = y_high_c;
		jump_d       = jump_c;
		dx_short     = sext7(first_byte_c);

		cmd.kind  = CMD_NONE;
		cmd.clear = item.new_file;
		cmd.dx    = delta_x_c;
		cmd.dy    = '0;
		cmd.jump  = jump_c;

		unique case (phase_c)
			PH_FIRST: begin
				first_byte_d = b;
				phase_d      = PH_SECOND;
			end
			PH_SECOND: begin
				if (first_byte_c == BYTE_END0 && b == BYTE_END1) begin
					cmd.kind = CMD_END;
					phase_d  = PH_ENDED;
				end else if (first_byte_c == BYTE_COL0 && b == BYTE_COL1) begin
					cmd.kind = CMD_COLOR;
					phase_d  = PH_SKIP;
				end else if (first_byte_c[7]) begin
					delta_x_d = sext12(first_byte_c[3:0], b);
					jump_d    = 1'b1;
					phase_d   = PH_YBYTE;
				end else if (b[7]) begin
					// short x, long y
					delta_x_d = dx_short;
					y_high_d  = b[3:0];
					jump_d    = 1'b1;
					phase_d   = PH_YLOW;
				end else begin
					delta_x_d = dx_short;
					jump_d    = 1'b0;
					cmd.kind  = CMD_STITCH;
					cmd.dx    = dx_short;
					cmd.dy    = sext7(b);
					cmd.jump  = 1'b0;
					phase_d   = PH_FIRST;
				end
			end
			PH_YBYTE: begin
				if (b[7]) begin
					y_high_d = b[3:0];
					jump_d   = 1'b1;
					phase_d  = PH_YLOW;
				end else begin
					cmd.kind = CMD_STITCH;
					cmd.dy   = sext7(b);
					phase_d  = PH_FIRST;
				end
			end
			PH_YLOW: begin
				cmd.kind = CMD_STITCH;
				cmd.dy   = sext12(y_high_c, b);
				phase_d  = PH_FIRST;
			end
			PH_SKIP:  phase_d = PH_FIRST;
			PH_ENDED: phase_d = PH_ENDED;
			default:  phase_d = PH_FIRST;
		endcase

		push = accept && (cmd.kind != CMD_NONE || item.new_file);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			first_byte_q <= '0;
			delta_x_q    <= '0;
			y_high_q     <= '0;
			jump_q       <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			first_byte_q <= first_byte_d;
			delta_x_q    <= delta_x_d;
			y_high_q     <= y_high_d;
			jump_q       <= jump_d;
		end
	end

endmodule

>>> hw/rtl/ssd_queue.sv
// Short command queue between front and back end.
// Depends on ssd_pkg.
module ssd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssd_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output ssd_pkg::cmd_t       head,
	output ssd_pkg::q_status_t  status
);
	import ssd_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign status.full      = (count_q == QCNT_W'(QDEPTH));
	assign status.not_empty = (count_q != '0);
	assign head             = entry_q[rd_ptr_q];
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/ssd_back.sv
// Back end: applies commands to positions, bounding box and block index,
// and holds the output register. Depends on ssd_pkg.
module ssd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ssd_pkg::cmd_t       head,
	input  ssd_pkg::q_status_t  q_status,
	output logic                pop,
	output logic                evt_valid,
	input  logic                evt_stall,
	output ssd_pkg::evt_item_t  evt_item
);
	import ssd_pkg::*;

	coord_t             acc_x_q, acc_y_q;
	coord_t             min_x_q, max_x_q, min_y_q, max_y_q;
	logic [BLOCK_W-1:0] block_q;
	logic               has_stitch_q;
	logic               evt_valid_q;
	evt_item_t          evt_item_q;

	coord_t             ax, ay, nx, ny;
	coord_t             mnx, mxx, mny, mxy;
	logic [BLOCK_W-1:0] blk;
	logic               has;
	evt_item_t          evt_d;

	assign pop       = q_status.not_empty && (!evt_valid_q || !evt_stall);
	assign evt_valid = evt_valid_q;
	assign evt_item  = evt_item_q;

	always_comb begin
		if (head.clear) begin
			ax  = '0;
			ay  = '0;
			mnx = '0;
			mxx = '0;
			mny = '0;
			mxy = '0;
			blk = '0;
			has = 1'b0;
		end else begin
			ax  = acc_x_q;
			ay  = acc_y_q;
			mnx = min_x_q;
			mxx = max_x_q;
			mny = min_y_q;
			mxy = max_y_q;
			blk = block_q;
			has = has_stitch_q;
		end
		nx = sat_add(ax, head.dx);
		ny = sat_add(ay, head.dy);

		evt_d.is_jump    = 1'b0;
		evt_d.event_kind = EV_STITCH;
		unique case (head.kind)
			CMD_STITCH: begin
				ax = nx;
				ay = ny;
				if (nx < mnx) mnx = nx;
				if (nx > mxx) mxx = nx;
				if (ny < mny) mny = ny;
				if (ny > mxy) mxy = ny;
				has              = 1'b1;
				evt_d.is_jump    = head.jump;
				evt_d.event_kind = EV_STITCH;
			end
			CMD_COLOR: begin
				// only open a new block when the current one has stitches
				if (has) begin
					if (blk < BLOCK_LAST)
						blk = blk + 1'b1;
					has = 1'b0;
				end
				evt_d.event_kind = EV_COLOR;
			end
			CMD_END:  evt_d.event_kind = EV_END;
			CMD_NONE: evt_d.event_kind = EV_STITCH;
			default:  evt_d.event_kind = EV_STITCH;
		endcase

		evt_d.pos_x        = to_out(ax);
		evt_d.pos_y        = to_out(ay);
		evt_d.block_number = blk;
		evt_d.min_x        = to_out(mnx);
		evt_d.max_x        = to_out(mxx);
		evt_d.min_y        = to_out(mny);
		evt_d.max_y        = to_out(mxy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			min_x_q      <= '0;
			max_x_q      <= '0;
			min_y_q      <= '0;
			max_y_q      <= '0;
			block_q      <= '0;
			has_stitch_q <= 1'b0;
			evt_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				acc_x_q      <= ax;
				acc_y_q      <= ay;
				min_x_q      <= mnx;
				max_x_q      <= mxx;
				min_y_q      <= mny;
				max_y_q      <= mxy;
				block_q      <= blk;
				has_stitch_q <= has;
			end
			if (pop && head.kind != CMD_NONE)
				evt_valid_q <= 1'b1;
			else if (!evt_stall)
				evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind != CMD_NONE)
			evt_item_q <= evt_d;
	end

endmodule

>>> hw/rtl/stitch_stream_decoder.sv
// Top level of the stitch stream decoder: front parser, command queue, back end.
// Depends on ssd_pkg, ssd_front, ssd_queue, ssd_back.
//
//   channel | dir | handshake              | payload
//   byte    | in  | byte_valid, byte_stall | byte_item (in_byte, new_file)
//   evt     | out | evt_valid, evt_stall   | evt_item (event kind, position, box)
//
// One byte is taken per cycle while byte_stall is low; the command for the last byte of
// a record is written into the queue, then its event into the output register, raising evt_valid.
// byte_stall rises only when the four-entry command queue is full, which happens
// only after evt_stall has held the output.
// Reset returns parser, positions, bounds and block index to zero.
module stitch_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  ssd_pkg::byte_item_t byte_item,
	output logic                evt_valid,
	input  logic                evt_stall,
	output ssd_pkg::evt_item_t  evt_item
);
	import ssd_pkg::*;

	logic      accept, push, pop;
	cmd_t      push_cmd, head;
	q_status_t q_status;

	assign byte_stall = q_status.full;
	assign accept     = byte_valid && !byte_stall;

	ssd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push),
		.cmd    (push_cmd)
	);

	ssd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	ssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_item  (evt_item)
	);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for stitch_stream_decoder: byte stream in, stitch events out.
// Depends on ssd_pkg and the decoder RTL; carries its own byte-level decoder
// prediction, a directed table, random record streams and random idling on both sides.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int N_ITEMS  = 750;
	// the directed table and the saturation run take the remaining bytes
	localparam int N_RANDOM = N_ITEMS - 310;
	localparam int SETTLE   = 8;

	typedef enum logic [2:0] {
		P_FIRST, P_SECOND, P_YBYTE, P_YLOW, P_SKIP, P_ENDED
	} parse_ph_t;

	typedef struct {
		logic [7:0] b;
		logic       nf;
		bit         fixed;
		evt_item_t  want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_item_t byte_item;
	logic       evt_valid;
	logic       evt_stall;
	evt_item_t  evt_item;

	stitch_stream_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_item  (evt_item)
	);

	always #2 clk = ~clk;

	// decoder state as predicted
	parse_ph_t  ph;
	logic [7:0] first_b;
	int         dx_hold;
	logic [3:0] y_hi;
	logic       jump_hold;
	int         acc_x, acc_y;
	int         lo_x, hi_x, lo_y, hi_y;
	int         blk_idx;
	logic       blk_used;

	evt_item_t  events_due[$];
	dir_row_t   dir_rows[$];
	int         fails = 0;
	int         taken = 0;
	int         quiet_left = 0;
	bit         fresh_file = 0;
	int         drift_x = 1, drift_y = 1;

	function automatic void clear_state();
		ph = P_FIRST;
		first_b = '0;
		dx_hold = 0;
		y_hi = '0;
		jump_hold = 1'b0;
		acc_x = 0;
		acc_y = 0;
		lo_x = 0;
		hi_x = 0;
		lo_y = 0;
		hi_y = 0;
		blk_idx = 0;
		blk_used = 1'b0;
	endfunction

	function automatic evt_item_t mk_evt(input logic [1:0] kind, input int px, input int py,
			input logic jmp, input int blk, input int mnx, input int mxx, input int mny,
			input int mxy);
		evt_item_t e;
		e.event_kind   = kind;
		e.pos_x        = 16'(px);
		e.pos_y        = 16'(py);
		e.is_jump      = jmp;
		e.block_number = 8'(blk);
		e.min_x        = 16'(mnx);
		e.max_x        = 16'(mxx);
		e.min_y        = 16'(mny);
		e.max_y        = 16'(mxy);
		return e;
	endfunction

	function automatic void add_row(input logic [7:0] b, input logic nf, input bit fixed,
			input evt_item_t want);
		dir_row_t row;
		row = '{b, nf, fixed, want};
		dir_rows = {dir_rows, row};
	endfunction

	function automatic evt_item_t snapshot(input logic [1:0] kind, input logic jmp);
		return mk_evt(kind, acc_x, acc_y, jmp, blk_idx, lo_x, hi_x, lo_y, hi_y);
	endfunction

	function automatic int clamp_coord(input int v);
		int top;
		top = (1 << (COORD_WIDTH - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic bit place_stitch(input int dy, output evt_item_t ev);
		acc_x = clamp_coord(acc_x + dx_hold);
		acc_y = clamp_coord(acc_y + dy);
		if (acc_x < lo_x) lo_x = acc_x;
		if (acc_x > hi_x) hi_x = acc_x;
		if (acc_y < lo_y) lo_y = acc_y;
		if (acc_y > hi_y) hi_y = acc_y;
		blk_used = 1'b1;
		ph = P_FIRST;
		ev = snapshot(EV_STITCH, jump_hold);
		return 1'b1;
	endfunction

	function automatic bit take_y(input logic [7:0] b, output evt_item_t ev);
		logic signed [6:0] s7;
		ev = '0;
		if (b[7]) begin
			y_hi = b[3:0];
			jump_hold = 1'b1;
			ph = P_YLOW;
			return 1'b0;
		end
		s7 = b[6:0];
		return place_stitch(s7, ev);
	endfunction

	// advances the predicted decoder by one byte; returns 1 when an event is due
	function automatic bit decode_byte(input byte_item_t it, output evt_item_t ev);
		logic [7:0]         b;
		logic signed [6:0]  s7;
		logic signed [11:0] s12;
		b = it.in_byte;
		ev = '0;
		if (it.new_file)
			clear_state();
		case (ph)
			P_FIRST: begin
				first_b = b;
				ph = P_SECOND;
				return 1'b0;
			end
			P_SECOND: begin
				if (first_b == BYTE_END0 && b == BYTE_END1) begin
					ph = P_ENDED;
					ev = snapshot(EV_END, 1'b0);
					return 1'b1;
				end
				if (first_b == BYTE_COL0 && b == BYTE_COL1) begin
					// only a block that holds stitches is closed
					if (blk_used) begin
						if (blk_idx < MAX_BLOCKS - 1)
							blk_idx++;
						blk_used = 1'b0;
					end
					ph = P_SKIP;
					ev = snapshot(EV_COLOR, 1'b0);
					return 1'b1;
				end
				if (first_b[7]) begin
					s12 = {first_b[3:0], b};
					dx_hold = s12;
					jump_hold = 1'b1;
					ph = P_YBYTE;
					return 1'b0;
				end
				s7 = first_b[6:0];
				dx_hold = s7;
				jump_hold = 1'b0;
				return take_y(b, ev);
			end
			P_YBYTE: return take_y(b, ev);
			P_YLOW: begin
				s12 = {y_hi, b};
				return place_stitch(s12, ev);
			end
			P_SKIP: begin
				ph = P_FIRST;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic nf, input bit fixed,
			input evt_item_t want);
		int        n;
		evt_item_t ev;
		bit        due;
		n = pick_gap();
		if (n > 0) begin
			byte_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		byte_item.in_byte  <= b;
		byte_item.new_file <= nf;
		byte_valid <= 1'b1;
		do
			@(posedge clk);
		while (byte_stall);
		if (nf || ph != P_ENDED)
			taken++;
		due = decode_byte('{in_byte: b, new_file: nf}, ev);
		if (fixed)
			events_due = {events_due, want};
		else if (due)
			events_due = {events_due, ev};
		@(negedge clk);
	endtask

	task automatic put(input logic [7:0] b);
		logic nf;
		nf = fresh_file;
		fresh_file = 0;
		if (nf) begin
			drift_x = $urandom_range(0, 1) ? 1 : -1;
			drift_y = $urandom_range(0, 1) ? 1 : -1;
		end
		send_byte(b, nf, 1'b0, '0);
	endtask

	// long form: bit 7 set, bits 6:4 don't care, 12-bit delta
	function automatic logic [15:0] long_pair(input int v);
		logic [11:0] d;
		d = v[11:0];
		return {1'b1, 3'($urandom_range(0, 7)), d};
	endfunction

	task automatic send_xy(input bit lx, input int vx, input bit ly, input int vy);
		logic [15:0] p;
		if (lx) begin
			p = long_pair(vx);
			put(p[15:8]);
			put(p[7:0]);
		end else
			put({1'b0, 7'(vx)});
		if (ly) begin
			p = long_pair(vy);
			put(p[15:8]);
			put(p[7:0]);
		end else
			put({1'b0, 7'(vy)});
	endtask

	task automatic wait_idle();
		byte_valid <= 1'b0;
		while (events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			fails++;
			if (fails <= 10)
				$display("%0t %s: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		evt_item_t w;
		if (arst_n && evt_valid && !evt_stall) begin
			if (events_due.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t unexpected event, kind %0d", $realtime, evt_item.event_kind);
			end else begin
				w = events_due.pop_front();
				check_field("event_kind", 16'(evt_item.event_kind), 16'(w.event_kind));
				check_field("pos_x", evt_item.pos_x, w.pos_x);
				check_field("pos_y", evt_item.pos_y, w.pos_y);
				check_field("is_jump", 16'(evt_item.is_jump), 16'(w.is_jump));
				check_field("block_number", 16'(evt_item.block_number), 16'(w.block_number));
				check_field("min_x", evt_item.min_x, w.min_x);
				check_field("max_x", evt_item.max_x, w.max_x);
				check_field("min_y", evt_item.min_y, w.min_y);
				check_field("max_y", evt_item.max_y, w.max_y);
			end
		end
	end

	// output back-pressure: short bursts, long holds and free stretches
	initial begin
		int r, len;
		logic v;
		evt_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				v = 1'b0;
				len = $urandom_range(1, 8);
			end else if (r < 75) begin
				v = 1'b1;
				len = $urandom_range(1, 2);
			end else if (r < 95) begin
				v = 1'b0;
				len = $urandom_range(20, 80);
			end else begin
				v = 1'b1;
				len = $urandom_range(10, 40);
			end
			repeat (len) begin
				@(negedge clk);
				evt_stall <= v;
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int r, n;
		byte_valid = 1'b0;
		byte_item = '0;
		arst_n = 1'b0;
		clear_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// end marker at the origin, then a byte that must be ignored
		add_row(8'hFF, 1'b1, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b1, mk_evt(EV_END, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(8'h12, 1'b0, 1'b0, '0);
		// colour change on an empty block keeps block 0
		add_row(8'hFE, 1'b1, 1'b0, '0);
		add_row(8'hB0, 1'b0, 1'b1, mk_evt(EV_COLOR, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(8'h55, 1'b0, 1'b0, '0);
		// short-form extremes
		add_row(8'h3F, 1'b0, 1'b0, '0);
		add_row(8'h40, 1'b0, 1'b1, mk_evt(EV_STITCH, 63, -64, 0, 0, 0, 63, -64, 0));
		// long-form extremes: +2047, -2048
		add_row(8'h87, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'h88, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		// colour change after stitches, then one on the now empty block
		add_row(8'hFE, 1'b0, 1'b0, '0);
		add_row(8'hB0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'hFE, 1'b0, 1'b0, '0);
		add_row(8'hB0, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		// short x with long y
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'h8F, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].nf, dir_rows[i].fixed, dir_rows[i].want);
		wait_idle();

		taken = 0;
		fresh_file = 1;
		while (taken < N_RANDOM) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				send_xy(0, $urandom_range(0, 127), 0, $urandom_range(0, 127));
			else if (r < 55)
				send_xy($urandom_range(0, 1), $urandom_range(0, 4095),
					$urandom_range(0, 1), $urandom_range(0, 4095));
			else if (r < 65)
				send_xy(1, drift_x * int'($urandom_range(1500, 2047)),
					$urandom_range(0, 1), drift_y * int'($urandom_range(1500, 2047)));
			else if (r < 73) begin
				put(BYTE_COL0);
				put(BYTE_COL1);
				put(8'($urandom));
			end else if (r < 76) begin
				put(BYTE_END0);
				put(BYTE_END1);
				repeat ($urandom_range(0, 3)) put(8'($urandom));
				fresh_file = 1;
			end else if (r < 84) begin
				// truncated record, cut off by a new file
				n = $urandom_range(1, 3);
				repeat (n) put(8'($urandom) | 8'h80);
				fresh_file = 1;
			end else if (r < 92)
				put(8'($urandom));
			else
				fresh_file = 1;
		end
		wait_idle();

		// positions driven into both saturation limits
		fresh_file = 1;
		n = $urandom_range(20, 28);
		repeat (n)
			send_xy(1, $urandom_range(1800, 2047), 1, $urandom_range(1800, 2047));
		repeat (45)
			send_xy(1, -int'($urandom_range(1800, 2048)), 1, -int'($urandom_range(1800, 2048)));
		put(BYTE_END0);
		put(BYTE_END1);
		wait_idle();

		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
